@@ design/modbus_rtu_read_holding_master_top_assert.svh @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_top_assert
// Assertion macros used by the Modbus RTU read-holding master RTL (mbrm_tx).
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_HOLDING_MASTER_TOP_ASSERT_SVH
`define MODBUS_RTU_READ_HOLDING_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define MBRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define MBRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrm_pkg
// Types, constants and the CRC-16 step of the Modbus RTU read-holding master.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrm_pkg;

  localparam int MAX_REGISTERS   = 125;
  localparam int MAX_FRAME_BYTES = 256;
  localparam int COUNT_W         = $clog2(MAX_REGISTERS + 1);
  localparam int RX_LEN_W        = $clog2(MAX_FRAME_BYTES + 1);
  localparam int REQ_BYTES       = 8;
  localparam int REQ_HDR_BYTES   = 6;
  localparam int POS_W           = $clog2(REQ_BYTES);
  localparam int MIN_REPLY_BYTES = 5;
  localparam int HEAD_BYTES      = 3;

  localparam logic [7:0]  FUNC_READ      = 8'h03;
  localparam logic [7:0]  FUNC_EXC_FLAG  = 8'h80;
  localparam logic [7:0]  FUNC_EXCEPTION = FUNC_READ | FUNC_EXC_FLAG;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_EOF   = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXCEPTION = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [31:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] ok_total;
    logic [15:0] timeout_total;
    logic [15:0] exception_total;
    logic [15:0] malformed_total;
  } stats_t;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   tx_byte;
    logic [6:0]   reg_index;
    logic [15:0]  reg_value;
    logic         success;
    status_e      status;
    logic [7:0]   exception_code;
    logic         last;
    stats_t       stats;
  } res_t;

  // Request bytes after the slave byte, index 0 is the function code.
  typedef logic [REQ_HDR_BYTES-2:0][7:0] req_tail_t;

  typedef struct packed {
    logic      valid;
    res_t      res;
    req_tail_t tail;
  } load_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x == CNT_MAX) ? x : x + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ design/modbus_rtu_read_holding_master_top.sv @@
// Path: a transaction waits in the input register, and its result, if any, enters
// the output register at the edge on which the core takes it from there.
// Throughput: one transaction per cycle while the output register is free; an
// accepted start holds it for eight request bytes, the CRC over the first six.
// Stalls on out_ready_i hold the output register and, through it, the input.
// Reset: all transaction state and counters clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_top
// Modbus RTU master for read holding registers: input register, core, output.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_read_holding_master_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  slave_id_i,
  input  wire logic [15:0] start_address_i,
  input  wire logic [15:0] register_count_i,
  input  wire logic [31:0] timeout_ticks_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       tx_byte_o,
  output logic [6:0]       reg_index_o,
  output logic [15:0]      reg_value_o,
  output logic             success_o,
  output logic [1:0]       status_o,
  output logic [7:0]       exception_code_o,
  output logic             last_o,
  output logic [15:0]      ok_total_o,
  output logic [15:0]      timeout_total_o,
  output logic [15:0]      exception_total_o,
  output logic [15:0]      malformed_total_o
);

  logic              item_valid_q;
  mbrm_pkg::item_t   item_q;
  logic              take;
  logic              em_free;
  mbrm_pkg::load_t   load;
  mbrm_pkg::res_t    res;

  assign in_ready_o = !item_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation      <= mbrm_pkg::op_e'(operation_i);
      item_q.slave_id       <= slave_id_i;
      item_q.start_address  <= start_address_i;
      item_q.register_count <= register_count_i;
      item_q.timeout_ticks  <= timeout_ticks_i;
      item_q.rx_byte        <= rx_byte_i;
    end
  end

  mbrm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .em_free_i    (em_free),
    .take_o       (take),
    .load_o       (load)
  );

  mbrm_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .free_o      (em_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o            = res.kind;
  assign tx_byte_o         = res.tx_byte;
  assign reg_index_o       = res.reg_index;
  assign reg_value_o       = res.reg_value;
  assign success_o         = res.success;
  assign status_o          = res.status;
  assign exception_code_o  = res.exception_code;
  assign last_o            = res.last;
  assign ok_total_o        = res.stats.ok_total;
  assign timeout_total_o   = res.stats.timeout_total;
  assign exception_total_o = res.stats.exception_total;
  assign malformed_total_o = res.stats.malformed_total;

endmodule

`default_nettype wire

@@ design/mbrm_core.sv @@
// ----------------------------------------------------------------------------
// mbrm_core
// Transaction state, reply tracking, verdicts and statistics counters.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrm_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire mbrm_pkg::item_t item_i,
  input  wire logic          em_free_i,
  output logic               take_o,
  output mbrm_pkg::load_t    load_o
);

  logic                          waiting_q, waiting_d;
  logic [7:0]                    want_slave_q, want_slave_d;
  logic [mbrm_pkg::COUNT_W-1:0]  want_count_q, want_count_d;
  logic [31:0]                   ticks_q, ticks_d;
  logic [mbrm_pkg::RX_LEN_W-1:0] rx_len_q, rx_len_d;
  logic [15:0]                   rx_crc_q, rx_crc_d;
  logic [2:0][7:0]               head_q, head_d;
  logic [7:0]                    high_q, high_d;
  mbrm_pkg::stats_t              stats_q, stats_d;

  logic [mbrm_pkg::RX_LEN_W-1:0] pos_m3;
  logic [6:0]                    word_idx;
  logic [31:0]                   ticks_dec;
  logic                          frame_ours;
  logic                          malformed;

  assign take_o    = item_valid_i && em_free_i;
  assign pos_m3    = rx_len_q - mbrm_pkg::RX_LEN_W'(mbrm_pkg::HEAD_BYTES);
  assign word_idx  = pos_m3[7:1];
  assign ticks_dec = (ticks_q != 32'd0) ? ticks_q - 32'd1 : ticks_q;

  assign frame_ours = waiting_q
      && (rx_len_q >= mbrm_pkg::RX_LEN_W'(mbrm_pkg::MIN_REPLY_BYTES))
      && (rx_crc_q == 16'h0000) && (head_q[0] == want_slave_q);
  assign malformed = (head_q[1] != mbrm_pkg::FUNC_READ)
      || (head_q[2] != {want_count_q, 1'b0})
      || (rx_len_q != ({1'b0, head_q[2]}
                       + mbrm_pkg::RX_LEN_W'(mbrm_pkg::MIN_REPLY_BYTES)));

  always_comb begin
    waiting_d    = waiting_q;
    want_slave_d = want_slave_q;
    want_count_d = want_count_q;
    ticks_d      = ticks_q;
    rx_len_d     = rx_len_q;
    rx_crc_d     = rx_crc_q;
    head_d       = head_q;
    high_d       = high_q;
    stats_d      = stats_q;
    load_o       = '0;

    if (take_o) begin
      case (item_i.operation)
        mbrm_pkg::OP_START: begin
          load_o.valid = 1'b1;
          if (waiting_q || (item_i.register_count == 16'd0)
              || (item_i.register_count > 16'(mbrm_pkg::MAX_REGISTERS))) begin
            load_o.res.kind = mbrm_pkg::KIND_REJECT;
            load_o.res.last = 1'b1;
          end else begin
            want_slave_d       = item_i.slave_id;
            want_count_d       = mbrm_pkg::COUNT_W'(item_i.register_count);
            ticks_d            = item_i.timeout_ticks;
            waiting_d          = 1'b1;
            load_o.res.kind    = mbrm_pkg::KIND_TX;
            load_o.res.tx_byte = item_i.slave_id;
            load_o.tail[0]     = mbrm_pkg::FUNC_READ;
            load_o.tail[1]     = item_i.start_address[15:8];
            load_o.tail[2]     = item_i.start_address[7:0];
            load_o.tail[3]     = item_i.register_count[15:8];
            load_o.tail[4]     = item_i.register_count[7:0];
          end
        end
        mbrm_pkg::OP_BYTE: begin
          // Bytes past the longest legal frame are dropped entirely.
          if (rx_len_q < mbrm_pkg::RX_LEN_W'(mbrm_pkg::MAX_FRAME_BYTES)) begin
            rx_crc_d = mbrm_pkg::crc_byte(rx_crc_q, item_i.rx_byte);
            rx_len_d = rx_len_q + 1'b1;
            if (rx_len_q < mbrm_pkg::RX_LEN_W'(mbrm_pkg::HEAD_BYTES)) begin
              head_d[rx_len_q[1:0]] = item_i.rx_byte;
            end else if (rx_len_q[0]) begin
              high_d = item_i.rx_byte;
            end else if (waiting_q && (head_q[1] == mbrm_pkg::FUNC_READ)
                         && (word_idx < want_count_q)) begin
              load_o.valid         = 1'b1;
              load_o.res.kind      = mbrm_pkg::KIND_WORD;
              load_o.res.reg_index = word_idx;
              load_o.res.reg_value = {high_q, item_i.rx_byte};
            end
          end
        end
        mbrm_pkg::OP_EOF: begin
          rx_len_d = '0;
          rx_crc_d = mbrm_pkg::CRC_INIT;
          head_d   = '0;
          high_d   = '0;
          if (frame_ours) begin
            waiting_d       = 1'b0;
            load_o.valid    = 1'b1;
            load_o.res.kind = mbrm_pkg::KIND_DONE;
            load_o.res.last = 1'b1;
            if (head_q[1] == mbrm_pkg::FUNC_EXCEPTION) begin
              stats_d.exception_total   = mbrm_pkg::sat_inc(stats_q.exception_total);
              load_o.res.status         = mbrm_pkg::ST_EXCEPTION;
              load_o.res.exception_code = head_q[2];
            end else if (malformed) begin
              stats_d.malformed_total = mbrm_pkg::sat_inc(stats_q.malformed_total);
              load_o.res.status       = mbrm_pkg::ST_MALFORMED;
            end else begin
              stats_d.ok_total   = mbrm_pkg::sat_inc(stats_q.ok_total);
              load_o.res.status  = mbrm_pkg::ST_OK;
              load_o.res.success = 1'b1;
            end
          end
        end
        mbrm_pkg::OP_TICK: begin
          if (waiting_q) begin
            ticks_d = ticks_dec;
            if (ticks_dec == 32'd0) begin
              waiting_d             = 1'b0;
              stats_d.timeout_total = mbrm_pkg::sat_inc(stats_q.timeout_total);
              load_o.valid          = 1'b1;
              load_o.res.kind       = mbrm_pkg::KIND_DONE;
              load_o.res.status     = mbrm_pkg::ST_TIMEOUT;
              load_o.res.last       = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Every result carries the counter values after this transaction.
    load_o.res.stats = stats_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q    <= 1'b0;
      want_slave_q <= '0;
      want_count_q <= '0;
      ticks_q      <= '0;
      rx_len_q     <= '0;
      rx_crc_q     <= mbrm_pkg::CRC_INIT;
      head_q       <= '0;
      high_q       <= '0;
      stats_q      <= '0;
    end else begin
      waiting_q    <= waiting_d;
      want_slave_q <= want_slave_d;
      want_count_q <= want_count_d;
      ticks_q      <= ticks_d;
      rx_len_q     <= rx_len_d;
      rx_crc_q     <= rx_crc_d;
      head_q       <= head_d;
      high_q       <= high_d;
      stats_q      <= stats_d;
    end
  end

endmodule

`default_nettype wire

@@ design/mbrm_tx.sv @@
// ----------------------------------------------------------------------------
// mbrm_tx
// Result register; serializes the six request header bytes and appends the two CRC bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_read_holding_master_top_assert.svh"

module mbrm_tx (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mbrm_pkg::load_t load_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output mbrm_pkg::res_t    res_o
);

  localparam logic [mbrm_pkg::POS_W-1:0] LastPos = mbrm_pkg::POS_W'(mbrm_pkg::REQ_BYTES - 1);
  localparam logic [mbrm_pkg::POS_W-1:0] CrcLoPos = mbrm_pkg::POS_W'(mbrm_pkg::REQ_HDR_BYTES);
  localparam logic [mbrm_pkg::POS_W-1:0] HdrEndPos =
      mbrm_pkg::POS_W'(mbrm_pkg::REQ_HDR_BYTES - 1);

  logic                          out_valid_q, out_valid_d;
  logic [mbrm_pkg::POS_W-1:0]    pos_q, pos_d;
  mbrm_pkg::res_t                res_q, res_d;
  mbrm_pkg::req_tail_t           tail_q, tail_d;
  logic [15:0]                   crc_q, crc_d;
  logic [15:0]                   crc_step;
  logic                          advance;

  assign advance     = out_valid_q && out_ready_i;
  assign free_o      = !out_valid_q || (out_ready_i && (pos_q == LastPos));
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign crc_step    = mbrm_pkg::crc_byte(crc_q, res_q.tx_byte);

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    res_d       = res_q;
    tail_d      = tail_q;
    crc_d       = crc_q;

    if (load_i.valid) begin
      out_valid_d = 1'b1;
      res_d       = load_i.res;
      if (load_i.res.kind == mbrm_pkg::KIND_TX) begin
        tail_d = load_i.tail;
        crc_d  = mbrm_pkg::CRC_INIT;
        pos_d  = '0;
      end else begin
        pos_d = LastPos;
      end
    end else if (advance) begin
      if (pos_q != LastPos) begin
        // The CRC absorbs each header byte as it leaves.
        pos_d      = pos_q + 1'b1;
        res_d.last = (pos_q == LastPos - 1'b1);
        if (pos_q < HdrEndPos) begin
          crc_d         = crc_step;
          res_d.tx_byte = tail_q[0];
          tail_d        = {8'h00, tail_q[mbrm_pkg::REQ_HDR_BYTES-2:1]};
        end else if (pos_q == HdrEndPos) begin
          crc_d         = crc_step;
          res_d.tx_byte = crc_step[7:0];
        end else begin
          res_d.tx_byte = crc_q[15:8];
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= LastPos;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    tail_q <= tail_d;
    crc_q  <= crc_d;
  end

  `MBRM_ASSERT_NOW(a_load_when_free, load_i.valid, free_o,
                   "result loaded while the output register is still busy")
  `MBRM_ASSERT_NOW(a_last_on_final_byte,
                   out_valid_q && (res_q.kind == mbrm_pkg::KIND_TX),
                   res_q.last == (pos_q == LastPos),
                   "request byte last flag out of step with its position")
  `MBRM_ASSERT_NEXT(a_frame_continues,
                    advance && (res_q.kind == mbrm_pkg::KIND_TX) && (pos_q != LastPos)
                      && (pos_q != CrcLoPos + 1'b1),
                    out_valid_q && (res_q.kind == mbrm_pkg::KIND_TX),
                    "request frame broken off before its last byte")

endmodule

`default_nettype wire
